>>> sv/amc_pkg.sv
// Shared types and constants of the rectangle move clamp block.
`timescale 1ns / 1ps

package amc_pkg;

  // Width of the table slot field of an input transaction.
  localparam int IDX_WIDTH = 6;

  // Command codes of an input transaction.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_MOVE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_entry;
    logic write_entry;
    logic load_move;
    logic scan;
    logic clamp;
    logic finish;
  } amc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } amc_status_t;

endpackage

>>> sv/amc_in_if.sv
// Input channel of the rectangle move clamp block.
`timescale 1ns / 1ps

interface amc_in_if #(
  parameter int COORD_WIDTH = 16,
  parameter int TAG_WIDTH   = 8
);
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [amc_pkg::IDX_WIDTH-1:0]       entry_index;
  logic signed [COORD_WIDTH-1:0]       pos_x;
  logic signed [COORD_WIDTH-1:0]       pos_y;
  logic [COORD_WIDTH-2:0]              size_w;
  logic [COORD_WIDTH-2:0]              size_h;
  logic                                collides;
  logic [TAG_WIDTH-1:0]                tag_bits;
  logic signed [COORD_WIDTH-1:0]       target_x;
  logic signed [COORD_WIDTH-1:0]       target_y;

  modport source (
    output valid, cmd, entry_index, pos_x, pos_y, size_w, size_h, collides, tag_bits,
           target_x, target_y,
    input  ready
  );

  modport sink (
    input  valid, cmd, entry_index, pos_x, pos_y, size_w, size_h, collides, tag_bits,
           target_x, target_y,
    output ready
  );
endinterface

>>> sv/amc_out_if.sv
// Result channel of the rectangle move clamp block.
`timescale 1ns / 1ps

interface amc_out_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] final_x;
  logic signed [COORD_WIDTH-1:0] final_y;

  modport source (
    output valid, final_x, final_y,
    input  ready
  );

  modport sink (
    input  valid, final_x, final_y,
    output ready
  );
endinterface

>>> sv/amc_ctrl.sv
// Controller state machine: table clearing, writes, table scan and clamp sequencing.
`timescale 1ns / 1ps

module amc_ctrl #(
  parameter int ENTRIES = 64,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_ready,
  output amc_pkg::amc_cmd_t    cmd,
  output logic [AW-1:0]        addr,
  input  amc_pkg::amc_status_t status
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_CLAMP = 3'd4;
  localparam logic [2:0] ST_FINAL = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          last;
  logic          in_fire;

  assign last     = (addr_r == AW'(ENTRIES - 1));
  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign addr     = addr_r;

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_entry = 1'b1;
        addr_nxt        = addr_r + 1'b1;
        if (last) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == amc_pkg::CMD_MOVE) begin
            cmd.load_move = 1'b1;
            addr_nxt      = '0;
            state_nxt     = ST_SCAN;
          end else begin
            cmd.write_entry = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (last) begin
          addr_nxt  = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Bounds are final once the compare pipeline has emptied.
        if (!status.pipe_busy) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end

endmodule

>>> sv/amc_dp.sv
// Datapath: rectangle table memory, compare pipeline, bound registers and output register.
`timescale 1ns / 1ps

module amc_dp #(
  parameter int ENTRIES     = 64,
  parameter int TAG_WIDTH   = 8,
  parameter int COORD_WIDTH = 16,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  amc_pkg::amc_cmd_t                cmd,
  input  logic [AW-1:0]                    addr,
  output amc_pkg::amc_status_t             status,
  input  logic [amc_pkg::IDX_WIDTH-1:0]    entry_index,
  input  logic signed [COORD_WIDTH-1:0]    pos_x,
  input  logic signed [COORD_WIDTH-1:0]    pos_y,
  input  logic [COORD_WIDTH-2:0]           size_w,
  input  logic [COORD_WIDTH-2:0]           size_h,
  input  logic                             collides,
  input  logic [TAG_WIDTH-1:0]             tag_bits,
  input  logic signed [COORD_WIDTH-1:0]    target_x,
  input  logic signed [COORD_WIDTH-1:0]    target_y,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [COORD_WIDTH-1:0]    final_x,
  output logic signed [COORD_WIDTH-1:0]    final_y
);

  localparam int C  = COORD_WIDTH;
  localparam int SW = COORD_WIDTH - 1;
  localparam int W  = COORD_WIDTH + 1;
  localparam int T  = TAG_WIDTH;
  localparam int MW = 2 * C + 2 * SW + 1 + T;
  localparam int XW = AW + amc_pkg::IDX_WIDTH;

  // Memory word layout, from the top: left, top, width, height, blocks, tags.
  localparam int O_TAGS = 0;
  localparam int O_BLK  = T;
  localparam int O_H    = T + 1;
  localparam int O_W    = O_H + SW;
  localparam int O_TOP  = O_W + SW;
  localparam int O_LEFT = O_TOP + C;

  localparam logic signed [W-1:0] COORD_MAX = {2'b00, {(C - 1){1'b1}}};

  logic [MW-1:0] mem [ENTRIES];
  logic [MW-1:0] rd_r;
  logic [MW-1:0] wdata;
  logic [AW-1:0] waddr;
  logic          we;
  logic [XW-1:0] idx_ext;
  logic          idx_ok;

  // Mover registers, sign-extended by one bit so that sums are exact.
  logic signed [W-1:0] px_r, py_r, pr_r, pb_r, w_r, h_r, tx_r, ty_r;
  logic [T-1:0]        mtag_r;
  logic signed [W-1:0] maxx_r, minx_r, maxy_r, miny_r;
  logic signed [W-1:0] midx_r, midy_r;

  logic signed [W-1:0] in_px, in_py, in_w, in_h, in_tx, in_ty;

  // Compare pipeline.
  logic                v_rd_r, v_a_r, v_b_r;
  logic signed [W-1:0] rd_ex, rd_ey, rd_ew, rd_eh;
  logic                rd_en;
  logic signed [W-1:0] a_ex_r, a_ey_r, a_er_r, a_eb_r, a_xmax_r, a_ymax_r;
  logic                a_en_r;
  logic                xov, yov, below, above, rgt, lft;
  logic                b_maxx_r, b_minx_r, b_maxy_r, b_miny_r;
  logic signed [W-1:0] b_xmax_r, b_xmin_r, b_ymax_r, b_ymin_r;

  logic signed [W-1:0] fx, fy;
  logic                out_valid_r;
  logic signed [C-1:0] final_x_r, final_y_r;

  // Table write port: clearing pass or write transaction.
  assign idx_ext = XW'(entry_index);
  assign idx_ok  = (idx_ext < XW'(ENTRIES));
  assign we      = cmd.clear_entry || (cmd.write_entry && idx_ok);
  assign waddr   = cmd.clear_entry ? addr : idx_ext[AW-1:0];
  assign wdata   = cmd.clear_entry ? '0
                 : {pos_x, pos_y, size_w, size_h, collides, tag_bits};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_r <= mem[addr];
    end
  end

  assign in_px = W'(pos_x);
  assign in_py = W'(pos_y);
  assign in_w  = W'(size_w);
  assign in_h  = W'(size_h);
  assign in_tx = W'(target_x);
  assign in_ty = W'(target_y);

  assign rd_ex = W'($signed(rd_r[O_LEFT +: C]));
  assign rd_ey = W'($signed(rd_r[O_TOP +: C]));
  assign rd_ew = W'(rd_r[O_W +: SW]);
  assign rd_eh = W'(rd_r[O_H +: SW]);
  assign rd_en = rd_r[O_BLK] && ((rd_r[O_TAGS +: T] & mtag_r) == '0);

  assign xov   = (a_ex_r < pr_r) && (px_r < a_er_r);
  assign yov   = (a_ey_r < pb_r) && (py_r < a_eb_r);
  assign below = (a_ey_r >= pb_r);
  assign above = (a_eb_r <= py_r);
  assign rgt   = (a_ex_r >= pr_r);
  assign lft   = (a_er_r <= px_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_rd_r <= 1'b0;
      v_a_r  <= 1'b0;
      v_b_r  <= 1'b0;
    end else begin
      v_rd_r <= cmd.scan;
      v_a_r  <= v_rd_r;
      v_b_r  <= v_a_r;
    end
  end

  // Stage A: entry edges and candidate bounds.
  always_ff @(posedge clk) begin
    a_ex_r   <= rd_ex;
    a_ey_r   <= rd_ey;
    a_er_r   <= rd_ex + rd_ew;
    a_eb_r   <= rd_ey + rd_eh;
    a_xmax_r <= rd_ex - w_r;
    a_ymax_r <= rd_ey - h_r;
    a_en_r   <= rd_en;
  end

  // Stage B: overlap and side tests select which bound an entry may tighten.
  always_ff @(posedge clk) begin
    b_maxy_r <= a_en_r && xov && below;
    b_miny_r <= a_en_r && xov && !below && above;
    b_maxx_r <= a_en_r && yov && rgt;
    b_minx_r <= a_en_r && yov && !rgt && lft;
    b_ymax_r <= a_ymax_r;
    b_ymin_r <= a_eb_r;
    b_xmax_r <= a_xmax_r;
    b_xmin_r <= a_er_r;
  end

  // Mover capture, bound updates and the first clamp step.
  always_ff @(posedge clk) begin
    if (cmd.load_move) begin
      px_r   <= in_px;
      py_r   <= in_py;
      pr_r   <= in_px + in_w;
      pb_r   <= in_py + in_h;
      w_r    <= in_w;
      h_r    <= in_h;
      tx_r   <= in_tx;
      ty_r   <= in_ty;
      mtag_r <= tag_bits;
      maxx_r <= (in_tx > in_px) ? in_tx : in_px;
      minx_r <= (in_tx < in_px) ? in_tx : in_px;
      maxy_r <= (in_ty > in_py) ? in_ty : in_py;
      miny_r <= (in_ty < in_py) ? in_ty : in_py;
    end else if (v_b_r) begin
      if (b_maxx_r && (b_xmax_r < maxx_r)) begin
        maxx_r <= b_xmax_r;
      end
      if (b_minx_r && (b_xmin_r > minx_r)) begin
        minx_r <= b_xmin_r;
      end
      if (b_maxy_r && (b_ymax_r < maxy_r)) begin
        maxy_r <= b_ymax_r;
      end
      if (b_miny_r && (b_ymin_r > miny_r)) begin
        miny_r <= b_ymin_r;
      end
    end
    if (cmd.clamp) begin
      midx_r <= (maxx_r < tx_r) ? maxx_r : tx_r;
      midy_r <= (maxy_r < ty_r) ? maxy_r : ty_r;
    end
  end

  // Second clamp step: the minimum bound wins, then saturate at the top of the range.
  assign fx = (minx_r > midx_r) ? minx_r : midx_r;
  assign fy = (miny_r > midy_r) ? miny_r : midy_r;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      final_x_r <= (fx > COORD_MAX) ? COORD_MAX[C-1:0] : fx[C-1:0];
      final_y_r <= (fy > COORD_MAX) ? COORD_MAX[C-1:0] : fy[C-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid        = out_valid_r;
  assign final_x          = final_x_r;
  assign final_y          = final_y_r;
  assign status.pipe_busy = v_rd_r || v_a_r || v_b_r;
  assign status.out_free  = !out_valid_r || out_ready;

endmodule

>>> sv/aabb_move_clamp.sv
// Rectangle move clamp: a move transaction walks the table one entry a cycle.
// A write transaction returns no result and leaves the block ready for the next one.
// A move transaction occupies the block while it scans the table through the single
// table read port, drains the compare pipeline and clamps its result.
// A waiting result does not hold off acceptance; a move cannot finish until it is taken.
// After reset a clearing pass zeroes every table entry with in_ch.ready low.
`timescale 1ns / 1ps

module aabb_move_clamp #(
  parameter int ENTRIES     = 64,
  parameter int TAG_WIDTH   = 8,
  parameter int COORD_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  amc_in_if.sink    in_ch,
  amc_out_if.source out_ch
);

  localparam int AW = $clog2(ENTRIES);

  amc_pkg::amc_cmd_t    cmd;
  amc_pkg::amc_status_t status;
  logic [AW-1:0]        addr;

  amc_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .addr     (addr),
    .status   (status)
  );

  amc_dp #(
    .ENTRIES     (ENTRIES),
    .TAG_WIDTH   (TAG_WIDTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .addr        (addr),
    .status      (status),
    .entry_index (in_ch.entry_index),
    .pos_x       (in_ch.pos_x),
    .pos_y       (in_ch.pos_y),
    .size_w      (in_ch.size_w),
    .size_h      (in_ch.size_h),
    .collides    (in_ch.collides),
    .tag_bits    (in_ch.tag_bits),
    .target_x    (in_ch.target_x),
    .target_y    (in_ch.target_y),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .final_x     (out_ch.final_x),
    .final_y     (out_ch.final_y)
  );

endmodule
